// ===== design/rv32i_pkg.sv =====
// shared types, opcodes and constants for the rv32i decode/execute block
// no dependencies
package rv32i_pkg;

    localparam int DATA_WORDS = 4096;
    localparam int DADDR_W = $clog2(DATA_WORDS);

    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
    localparam logic [6:0]  F7_ALT     = 7'h20;

    typedef struct packed {
        logic        command;
        logic [31:0] instruction;
        logic [11:0] preload_address;
        logic [31:0] preload_data;
    } t_in_word;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic        store_done;
        logic        halted;
        logic        unknown_instruction;
        logic        misaligned;
    } t_out_word;

    // per-word record handed from the front to the back
    typedef struct packed {
        logic        preload;
        logic [31:0] instruction;
        logic [31:0] preload_data;
        logic [DADDR_W-1:0] preload_index;
    } t_queue_word;

endpackage

// ===== design/rv32i_ram.sv =====
// generic single-port-write, single-read ram with registered read
// no dependencies
module rv32i_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/rv32i_front.sv =====
// front part: accepts input words and holds them in a two-entry queue
// uses rv32i_pkg
module rv32i_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  rv32i_pkg::t_in_word   i_word,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output rv32i_pkg::t_queue_word o_q_word
);
    import rv32i_pkg::*;

    t_queue_word r_q [2];
    logic        r_rd, r_wr;
    logic [1:0]  r_cnt;
    t_queue_word n_entry;
    logic        push;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_word  = r_q[r_rd];

    always_comb begin
        n_entry.preload       = i_word.command;
        n_entry.instruction   = i_word.instruction;
        n_entry.preload_data  = i_word.preload_data;
        n_entry.preload_index = DADDR_W'(i_word.preload_address % DATA_WORDS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_q_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
        if (push) begin
            r_q[r_wr] <= n_entry;
        end
    end
endmodule

// ===== design/rv32i_back.sv =====
// back part: register file, pc, data memory access and result register
// uses rv32i_pkg and rv32i_ram
module rv32i_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [31:0]            i_cfg_data,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  rv32i_pkg::t_queue_word i_q_word,
    output logic                   o_valid,
    input  logic                   i_ready,
    output rv32i_pkg::t_out_word   o_word
);
    import rv32i_pkg::*;

    logic [31:0] r_rf [32];
    logic [31:0] r_pc;
    logic        r_halt;
    logic        r_busy;     // item in execution: memory read data available
    t_queue_word r_item;
    logic [31:0] r_a, r_b, r_addr;
    logic        r_out_valid;
    t_out_word   r_out;

    logic        start;
    logic [31:0] ins;
    logic [6:0]  op, f7;
    logic [2:0]  f3;
    logic [4:0]  rd;
    logic [31:0] imm_i, imm_b, imm_j, mem_q, mem_wd, alu_b, alu_r;
    logic [DADDR_W-1:0] mem_ra, mem_wa;
    logic        mem_we, alt, take, wr, st, unk, mis;
    logic [31:0] val, npc;
    logic [4:0]  lane;
    logic [7:0]  byte_q;
    t_out_word   n_out;

    // an item starts only when no item is executing and the output slot is free or being emptied
    assign start   = i_q_valid && !r_busy && (!r_out_valid || i_ready);
    assign o_q_pop = start;
    assign o_valid = r_out_valid;
    assign o_word  = r_out;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_item <= i_q_word;
            r_a    <= r_rf[i_q_word.instruction[19:15]];
            r_b    <= r_rf[i_q_word.instruction[24:20]];
            r_addr <= r_rf[i_q_word.instruction[19:15]] + (i_q_word.instruction[6:0] == OP_STORE
                ? {{20{i_q_word.instruction[31]}}, i_q_word.instruction[31:25],
                   i_q_word.instruction[11:7]}
                : {{20{i_q_word.instruction[31]}}, i_q_word.instruction[31:20]});
        end
    end

    assign mem_ra = start ? DADDR_W'((r_rf[i_q_word.instruction[19:15]]
                        + (i_q_word.instruction[6:0] == OP_STORE
                        ? {{20{i_q_word.instruction[31]}}, i_q_word.instruction[31:25],
                           i_q_word.instruction[11:7]}
                        : {{20{i_q_word.instruction[31]}}, i_q_word.instruction[31:20]}))
                        >> 2) : DADDR_W'(r_addr >> 2);

    rv32i_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_q)
    );

    assign ins   = r_item.instruction;
    assign op    = ins[6:0];
    assign f3    = ins[14:12];
    assign f7    = ins[31:25];
    assign rd    = ins[11:7];
    assign imm_i = {{20{ins[31]}}, ins[31:20]};
    assign imm_b = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
    assign imm_j = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
    assign lane  = {r_addr[1:0], 3'b000};
    assign byte_q = 8'(mem_q >> lane);
    assign alu_b = (op == OP_REG) ? r_b
                 : ((f3 == 3'd1 || f3 == 3'd5) ? {27'd0, ins[24:20]} : imm_i);
    assign alt   = (op == OP_REG) ? (f7 == F7_ALT) : (f3 == 3'd5 && f7 == F7_ALT);

    always_comb begin
        unique case (f3)
            3'd0: alu_r = alt ? r_a - alu_b : r_a + alu_b;
            3'd1: alu_r = r_a << alu_b[4:0];
            3'd2: alu_r = {31'd0, $signed(r_a) < $signed(alu_b)};
            3'd3: alu_r = {31'd0, r_a < alu_b};
            3'd4: alu_r = r_a ^ alu_b;
            3'd5: alu_r = alt ? 32'($signed(r_a) >>> alu_b[4:0]) : r_a >> alu_b[4:0];
            3'd6: alu_r = r_a | alu_b;
            default: alu_r = r_a & alu_b;
        endcase
    end

    always_comb begin
        wr = 1'b0; st = 1'b0; unk = 1'b0; mis = 1'b0; take = 1'b0;
        val = 32'd0;
        npc = r_pc + 32'd4;
        mem_we = 1'b0;
        mem_wa = DADDR_W'(r_addr >> 2);
        mem_wd = r_b;
        unique case (op)
            OP_REG: begin
                if (f7 == 7'd0 || (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
                    wr = 1'b1; val = alu_r;
                end else begin
                    unk = 1'b1;
                end
            end
            OP_IMM: begin
                if ((f3 == 3'd1 && f7 != 7'd0)
                        || (f3 == 3'd5 && f7 != 7'd0 && f7 != F7_ALT)) begin
                    unk = 1'b1;
                end else begin
                    wr = 1'b1; val = alu_r;
                end
            end
            OP_LOAD: begin
                if (f3 == 3'd0) begin
                    wr = 1'b1; val = {{24{byte_q[7]}}, byte_q};
                end else if (f3 == 3'd4) begin
                    wr = 1'b1; val = {24'd0, byte_q};
                end else if (f3 == 3'd2) begin
                    if (r_addr[1:0] != 2'd0) mis = 1'b1;
                    else begin
                        wr = 1'b1; val = mem_q;
                    end
                end else begin
                    unk = 1'b1;
                end
            end
            OP_STORE: begin
                if (f3 == 3'd0) begin
                    st = 1'b1;
                    mem_wd = (mem_q & ~(32'hFF << lane)) | ({24'd0, r_b[7:0]} << lane);
                end else if (f3 == 3'd2) begin
                    if (r_addr[1:0] != 2'd0) mis = 1'b1;
                    else st = 1'b1;
                end else begin
                    unk = 1'b1;
                end
            end
            OP_BRANCH: begin
                unique case (f3)
                    3'd0: take = r_a == r_b;
                    3'd1: take = r_a != r_b;
                    3'd4: take = $signed(r_a) < $signed(r_b);
                    3'd5: take = !($signed(r_a) < $signed(r_b));
                    3'd6: take = r_a < r_b;
                    3'd7: take = r_a >= r_b;
                    default: unk = 1'b1;
                endcase
                if (take) npc = r_pc + imm_b;
            end
            OP_JAL: begin
                wr = 1'b1; val = r_pc + 32'd4; npc = r_pc + imm_j;
            end
            OP_JALR: begin
                if (f3 != 3'd0) unk = 1'b1;
                else begin
                    wr = 1'b1; val = r_pc + 32'd4;
                    npc = (r_a + imm_i) & ~32'd1;
                end
            end
            OP_LUI: begin
                wr = 1'b1; val = {ins[31:12], 12'd0};
            end
            OP_AUIPC: begin
                wr = 1'b1; val = r_pc + {ins[31:12], 12'd0};
            end
            OP_SYSTEM: begin
                if (ins != ECALL_WORD) unk = 1'b1;
            end
            default: unk = 1'b1;
        endcase
        if (rd == 5'd0) wr = 1'b0;

        n_out = '0;
        if (r_item.preload) begin
            mem_we = 1'b1;
            mem_wa = r_item.preload_index;
            mem_wd = r_item.preload_data;
            n_out.next_pc = r_pc;
            n_out.halted  = r_halt;
        end else if (r_halt) begin
            n_out.next_pc = r_pc;
            n_out.halted  = 1'b1;
        end else begin
            mem_we = st;
            n_out.next_pc             = npc;
            n_out.reg_write           = wr;
            n_out.dest_index          = wr ? rd : 5'd0;
            n_out.dest_value          = wr ? val : 32'd0;
            n_out.store_done          = st;
            n_out.halted              = (op == OP_SYSTEM && ins == ECALL_WORD);
            n_out.unknown_instruction = unk;
            n_out.misaligned          = mis;
        end
        if (!r_busy) mem_we = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= 32'd0;
            r_halt      <= 1'b0;
            for (int i = 0; i < 32; i++) r_rf[i] <= 32'd0;
        end else begin
            r_busy <= start;
            if (r_out_valid && i_ready) r_out_valid <= 1'b0;
            if (i_cfg_we) r_pc <= i_cfg_data;
            if (r_busy) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
                if (!r_item.preload && !r_halt) begin
                    r_pc   <= npc;
                    r_halt <= n_out.halted;
                    if (wr) r_rf[rd] <= val;
                end
            end
        end
    end
endmodule

// ===== design/rv32i_decode_execute_top.sv =====
// top level of the rv32i decode/execute block
// uses rv32i_pkg, rv32i_front, rv32i_back
// Each word (an instruction or a data preload) passes the back end in order:
// the register file is read and the data memory read issued, then the word
// executes, writes back and registers its result. A two-entry queue in front
// takes new words while the back end works; because of the registered data
// memory read, the back end starts a new word only after finishing the last.
// Writing start_address loads the pc; write it only while idle.
module rv32i_decode_execute_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  rv32i_pkg::t_in_word  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rv32i_pkg::t_out_word o_data
);
    import rv32i_pkg::*;

    logic        q_valid, q_pop;
    t_queue_word q_word;

    rv32i_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_word    (i_data),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop),
        .o_q_word  (q_word)
    );

    rv32i_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_q_word   (q_word),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_word     (o_data)
    );
endmodule

// ===== design/rv32i_checker.sv =====
// port-level checks for the rv32i decode/execute block
// uses rv32i_pkg; bound to rv32i_decode_execute_top
module rv32i_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input rv32i_pkg::t_out_word o_data
);
    import rv32i_pkg::*;

    // a write of x0 is never reported
    a_no_x0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_data.reg_write && o_data.dest_index == 5'd0))
        else $error("x0 write reported");

    // at most one event flag per word
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0({o_data.reg_write, o_data.store_done,
                              o_data.unknown_instruction, o_data.misaligned}))
        else $error("conflicting flags");

    // halt is sticky: a result that directly follows a delivered halted one is halted
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.halted) ##1 o_valid |-> o_data.halted)
        else $error("halt cleared");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped while stalled");
endmodule

bind rv32i_decode_execute_top rv32i_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ===== test/rv32i_exec_checker.sv =====
// checker for rv32i_decode_execute_top: tracks register file, pc, data memory
// and halt flag from the accepted words and compares every result word
// depends on rv32i_pkg
module rv32i_exec_checker
    import rv32i_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic      i_valid,
    input  logic      i_ready_in,
    input  t_in_word  i_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_data,
    output int        o_pending,
    output int        o_fail_count,
    output int        o_results
);

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_SB   = 3'd0;
    localparam logic [2:0] F3_SW   = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    logic [31:0] regs [32];
    logic [31:0] pc;
    logic [31:0] mem [DATA_WORDS];
    logic        halt;
    t_out_word   expected_results [$];
    int          fails;
    int          results;

    assign o_pending    = expected_results.size();
    assign o_fail_count = fails;
    assign o_results    = results;

    function automatic logic [31:0] alu(logic [2:0] f3, logic alt, logic [31:0] a,
                                        logic [31:0] b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    task automatic execute_word(input t_in_word w, output t_out_word r);
        logic [31:0] ins, a, b, val, npc, addr, wd, imm_i, imm_s, imm_b, imm_j;
        logic [6:0]  op, f7;
        logic [2:0]  f3;
        logic [4:0]  rd, lane;
        logic        wr, st, unk, mis, take;
        logic [DADDR_W-1:0] widx;
        ins = w.instruction;
        op = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        rd = ins[11:7];
        a = regs[ins[19:15]];
        b = regs[ins[24:20]];
        imm_i = {{20{ins[31]}}, ins[31:20]};
        imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        wr = 0; st = 0; unk = 0; mis = 0; take = 0; val = 0;
        npc = pc;
        if (w.command) begin
            mem[w.preload_address[DADDR_W-1:0]] = w.preload_data;
        end else if (!halt) begin
            npc = pc + 4;
            case (op)
                OP_REG: begin
                    if (f7 == 0 || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
                        wr = 1;
                        val = alu(f3, f7 == F7_ALT, a, b);
                    end else begin
                        unk = 1;
                    end
                end
                OP_IMM: begin
                    if (f3 == F3_SLL && f7 != 0) unk = 1;
                    else if (f3 == F3_SR && f7 != 0 && f7 != F7_ALT) unk = 1;
                    else begin
                        wr = 1;
                        val = alu(f3, f3 == F3_SR && f7 == F7_ALT, a,
                                  (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, ins[24:20]} : imm_i);
                    end
                end
                OP_LOAD: begin
                    addr = a + imm_i;
                    widx = addr[DADDR_W+1:2];
                    lane = {addr[1:0], 3'b000};
                    wd = mem[widx] >> lane;
                    if (f3 == F3_LB) begin
                        wr = 1;
                        val = {{24{wd[7]}}, wd[7:0]};
                    end else if (f3 == F3_LBU) begin
                        wr = 1;
                        val = {24'd0, wd[7:0]};
                    end else if (f3 == F3_LW) begin
                        if (addr[1:0] != 0) mis = 1;
                        else begin
                            wr = 1;
                            val = mem[widx];
                        end
                    end else begin
                        unk = 1;
                    end
                end
                OP_STORE: begin
                    addr = a + imm_s;
                    widx = addr[DADDR_W+1:2];
                    lane = {addr[1:0], 3'b000};
                    if (f3 == F3_SB) begin
                        mem[widx] = (mem[widx] & ~(32'hFF << lane)) | ({24'd0, b[7:0]} << lane);
                        st = 1;
                    end else if (f3 == F3_SW) begin
                        if (addr[1:0] != 0) mis = 1;
                        else begin
                            mem[widx] = b;
                            st = 1;
                        end
                    end else begin
                        unk = 1;
                    end
                end
                OP_BRANCH: begin
                    case (f3)
                        F3_BEQ:  take = a == b;
                        F3_BNE:  take = a != b;
                        F3_BLT:  take = $signed(a) < $signed(b);
                        F3_BGE:  take = $signed(a) >= $signed(b);
                        F3_BLTU: take = a < b;
                        F3_BGEU: take = a >= b;
                        default: unk = 1;
                    endcase
                    if (take) npc = pc + imm_b;
                end
                OP_JAL: begin
                    wr = 1;
                    val = pc + 4;
                    npc = pc + imm_j;
                end
                OP_JALR: begin
                    if (f3 != 0) unk = 1;
                    else begin
                        wr = 1;
                        val = pc + 4;
                        npc = (a + imm_i) & ~32'd1;
                    end
                end
                OP_LUI: begin
                    wr = 1;
                    val = {ins[31:12], 12'd0};
                end
                OP_AUIPC: begin
                    wr = 1;
                    val = pc + {ins[31:12], 12'd0};
                end
                OP_SYSTEM: begin
                    if (ins == ECALL_WORD) halt = 1;
                    else unk = 1;
                end
                default: unk = 1;
            endcase
            // x0 never takes a write
            if (rd == 0) wr = 0;
            if (wr) regs[rd] = val;
            pc = npc;
        end
        r.next_pc = npc;
        r.reg_write = wr;
        r.dest_index = wr ? rd : 5'd0;
        r.dest_value = wr ? val : 32'd0;
        r.store_done = st;
        r.halted = halt;
        r.unknown_instruction = unk;
        r.misaligned = mis;
    endtask

    always @(posedge i_clk) begin
        t_out_word exp_w;
        t_out_word got;
        logic      bad;
        if (!i_rst_n) begin
            for (int i = 0; i < 32; i++) regs[i] = 0;
            pc = 0;
            halt = 0;
            expected_results.delete();
            fails = 0;
            results = 0;
        end else begin
            if (i_cfg_we) pc = i_cfg_data;
            if (i_valid && i_ready_in) begin
                execute_word(i_data, exp_w);
                expected_results.push_back(exp_w);
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                results++;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("unexpected result word %p", got);
                end else begin
                    exp_w = expected_results.pop_front();
                    bad = 0;
                    if (got.next_pc !== exp_w.next_pc) bad = 1;
                    if (got.reg_write !== exp_w.reg_write) bad = 1;
                    if (got.dest_index !== exp_w.dest_index) bad = 1;
                    if (got.dest_value !== exp_w.dest_value) bad = 1;
                    if (got.store_done !== exp_w.store_done) bad = 1;
                    if (got.halted !== exp_w.halted) bad = 1;
                    if (got.unknown_instruction !== exp_w.unknown_instruction) bad = 1;
                    if (got.misaligned !== exp_w.misaligned) bad = 1;
                    if (bad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("mismatch at result %0d", results);
                            $display("  expected %p", exp_w);
                            $display("  actual   %p", got);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
// testbench top for rv32i_decode_execute_top: drives instruction and preload
// words, pacing and start addresses; rv32i_exec_checker does the checking
// depends on rv32i_pkg, rv32i_exec_checker and the design
module tb_top;
    import rv32i_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [31:0] i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    t_in_word    i_data = '0;
    logic        o_valid;
    logic        i_ready = 0;
    t_out_word   o_data;

    int pending, fail_count, results;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_len = 0;
    int hold_seq = 0;
    int words_sent = 0;

    always #10 i_clk = ~i_clk;

    rv32i_decode_execute_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
    );

    rv32i_exec_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .i_ready_in(o_ready), .i_data(i_data),
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_data(o_data),
        .o_pending(pending), .o_fail_count(fail_count), .o_results(results)
    );

    // receiver pacing, with one long hold-off
    int hold_cnt = 0;
    int hold_seen = 0;
    always @(posedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_cnt = hold_len;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_ready <= 0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout with %0d results outstanding", pending);
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                          logic [4:0] rd, logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                          logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // random instruction, mostly well formed, never the exact ecall word
    // loads and byte stores stay off x0 inside the preloaded low words
    function automatic logic [31:0] random_instr();
        logic [31:0] w;
        logic [6:0]  f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [11:0] imm;
        int          sel;
        w = $urandom;
        rd = $urandom;
        rs1 = $urandom;
        rs2 = $urandom;
        f3 = $urandom;
        imm = $urandom;
        sel = $urandom_range(99);
        f7 = (sel % 3 == 0) ? F7_ALT : ((sel % 7 == 0) ? 7'($urandom) : 7'd0);
        // aligned addresses off x0 give word accesses a fair chance
        if ($urandom_range(1)) begin
            rs1 = 0;
            imm[1:0] = 0;
        end
        if (sel < 18) w = enc_r(f7, rs2, rs1, f3, rd, OP_REG);
        else if (sel < 36) w = (f3 == 1 || f3 == 5) ? enc_r(f7, rs2, rs1, f3, rd, OP_IMM)
                                                  : enc_i(imm, rs1, f3, rd, OP_IMM);
        else if (sel < 50) w = enc_i({2'b00, imm[9:0]}, 5'd0,
                                     $urandom_range(3) == 0 ? 3'($urandom)
                                     : ($urandom_range(1) ? 3'd2 : 3'($urandom_range(1) * 4)),
                                     rd, OP_LOAD);
        else if (sel < 62) begin
            f3 = $urandom_range(4) == 0 ? 3'($urandom) : 3'($urandom_range(1) * 2);
            w = (f3 == 3'd0) ? enc_s({2'b00, imm[9:0]}, rs2, 5'd0, f3)
                             : enc_s(imm, rs2, rs1, f3);
        end
        else if (sel < 74) w = enc_b({imm, 1'b0}, rs2, rs1, f3);
        else if (sel < 78) w = enc_j(21'($urandom), rd);
        else if (sel < 82) w = enc_i(imm, rs1, $urandom_range(4) == 0 ? f3 : 3'd0, rd, OP_JALR);
        else if (sel < 87) w = {w[31:12], rd, OP_LUI};
        else if (sel < 92) w = {w[31:12], rd, OP_AUIPC};
        else if (sel < 94) w = {w[31:7], OP_SYSTEM};
        else if (w[6:0] == OP_LOAD || w[6:0] == OP_STORE) w[0] = 1'b0;
        if (w == ECALL_WORD) w[31] = 1;
        return w;
    endfunction

    task automatic send(input logic cmd, input logic [31:0] ins, input logic [11:0] paddr,
                        input logic [31:0] pdata);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_data <= '{command: cmd, instruction: ins, preload_address: paddr,
                    preload_data: pdata};
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic exec_word(input logic [31:0] ins);
        send(0, ins, 12'($urandom), $urandom);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_start(input logic [31:0] addr);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= addr;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_phase(input int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(19) == 0) send(1, $urandom, 12'($urandom), $urandom);
            else exec_word(random_instr());
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // fill the low data words and the top one so no load sees an unwritten word
        set_start(32'hFFFF_FFFF);
        tx_idle = 10;
        rx_idle = 10;
        for (int k = 0; k < 256; k++) send(1, $urandom, 12'(k), $urandom);
        send(1, $urandom, 12'(DATA_WORDS - 1), $urandom);

        set_start(32'h0000_0000);
        exec_word({20'h80000, 5'd1, OP_LUI});
        // high address wraps onto word 0, negative offset onto the top word
        exec_word(enc_i(12'd0, 1, 3'd2, 18, OP_LOAD));
        exec_word(enc_i(-12'sd4, 0, 3'd2, 19, OP_LOAD));
        exec_word(enc_i(-12'sd1, 0, 3'd0, 2, OP_IMM));
        exec_word(enc_r(0, 2, 1, 3'd0, 3, OP_REG));
        exec_word(enc_r(F7_ALT, 2, 0, 3'd0, 4, OP_REG));
        exec_word(enc_r(F7_ALT, 2, 1, 3'd5, 5, OP_REG));
        exec_word(enc_r(0, 2, 1, 3'd5, 6, OP_REG));
        exec_word(enc_r(0, 2, 2, 3'd1, 7, OP_REG));
        exec_word(enc_r(0, 4, 1, 3'd2, 8, OP_REG));
        exec_word(enc_r(0, 4, 1, 3'd3, 9, OP_REG));
        exec_word(enc_r(F7_ALT, 5'd4, 1, 3'd5, 10, OP_IMM));
        exec_word(enc_r(F7_ALT, 5'd4, 1, 3'd1, 11, OP_IMM));
        exec_word(enc_i(12'd5, 2, 3'd0, 0, OP_IMM));
        exec_word(enc_s(12'd8, 2, 0, 3'd2));
        exec_word(enc_s(12'd11, 4, 0, 3'd0));
        exec_word(enc_i(12'd11, 0, 3'd0, 12, OP_LOAD));
        exec_word(enc_i(12'd8, 0, 3'd4, 13, OP_LOAD));
        exec_word(enc_i(12'd8, 0, 3'd2, 14, OP_LOAD));
        exec_word(enc_i(12'd9, 0, 3'd2, 14, OP_LOAD));
        exec_word(enc_s(12'd6, 2, 0, 3'd2));
        exec_word(enc_i(12'd0, 0, 3'd1, 14, OP_LOAD));
        exec_word(enc_b(13'd8, 0, 0, 3'd0));
        exec_word(enc_b(-13'sd4, 2, 4, 3'd6));
        exec_word(enc_b(13'd16, 4, 1, 3'd5));
        exec_word(enc_b(13'd16, 4, 1, 3'd2));
        exec_word(enc_j(-21'sd16, 15));
        exec_word(enc_i(12'd0, 2, 3'd0, 16, OP_JALR));
        exec_word(enc_i(12'd0, 2, 3'd1, 16, OP_JALR));
        exec_word({20'hFFFFF, 5'd17, OP_AUIPC});
        exec_word(32'h0010_0073);

        // receiver stalls long while words keep coming
        set_start(32'h8000_0000);
        tx_idle = 8;
        rx_idle = 77;
        hold_len = 300;
        hold_seq++;
        random_phase(150);

        set_start($urandom);
        tx_idle = 77;
        rx_idle = 8;
        random_phase(150);

        set_start(32'hFFFF_FFFC);
        tx_idle = 0;
        rx_idle = 0;
        random_phase(150);

        // halt, then check that execution stops but preload still works
        exec_word(ECALL_WORD);
        for (int k = 0; k < 5; k++) exec_word(random_instr());
        send(1, $urandom, 12'($urandom), $urandom);
        drain();
        repeat (20) @(posedge i_clk);

        $display("sent %0d words (low memory preload, directed, three pacing phases,",
                 words_sent);
        $display("halt at the end); %0d result words compared", results);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
